### hdl/assert_macros.svh
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### hdl/dxt_pkg.sv
// Shared types and constants of the DXT block decoder.
`timescale 1ns / 1ps

package dxt_pkg;

   // Format codes
   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam int SIDE_W  = 13;
   localparam int BLK_W   = 10;
   localparam int COORD_W = 12;

   localparam logic [SIDE_W-1:0] MAX_IMAGE_SIDE = 13'd4096;
   localparam logic [SIDE_W-1:0] WIDTH_RESET    = 13'd512;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET   = 13'd512;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } color_type;

   typedef struct packed {
      color_type [3:0]  color;
      logic [7:0][7:0]  alpha;
   } palette_type;

endpackage

### hdl/dxt_palette.sv
// Colour and alpha palette construction for one compressed block.
`timescale 1ns / 1ps

module dxt_palette (
   input  logic [63:0]          color_block,
   input  logic [63:0]          alpha_block,
   input  logic [1:0]           block_format,
   output dxt_pkg::palette_type palette
);

   // v*255/31 = 8v + floor(7v/31); the floor by reciprocal multiply
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0]  n;
      logic [16:0] prod;
      n    = 8'(v) * 8'd7;
      prod = 17'(n) * 17'd265;
      return {v, 3'b000} + 8'(prod[15:13]);
   endfunction

   // v*255/63 = 4v + floor(v/21)
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] f;
      f = (v == 6'd63) ? 2'd3 : ((v >= 6'd42) ? 2'd2 : ((v >= 6'd21) ? 2'd1 : 2'd0));
      return {v, 2'b00} + 8'(f);
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [20:0] prod;
      prod = 21'(n) * 21'd683;
      return prod[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] n);
      logic [21:0] prod;
      prod = 22'(n) * 22'd1639;
      return prod[20:13];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] n);
      logic [24:0] prod;
      prod = 25'(n) * 25'd2341;
      return prod[21:14];
   endfunction

   logic [15:0] c0, c1;
   logic [7:0]  a0, a1;
   logic        four;
   logic [7:0]  e0 [3];
   logic [7:0]  e1 [3];
   logic [7:0]  p2 [3];
   logic [7:0]  p3 [3];
   logic [7:0]  apal [8];

   assign c0   = color_block[15:0];
   assign c1   = color_block[31:16];
   assign a0   = alpha_block[7:0];
   assign a1   = alpha_block[15:8];
   assign four = (c0 > c1) || (block_format == dxt_pkg::FMT_DXT3)
                 || (block_format == dxt_pkg::FMT_DXT5);

   always_comb begin
      e0[0] = expand5(c0[15:11]);
      e0[1] = expand6(c0[10:5]);
      e0[2] = expand5(c0[4:0]);
      e1[0] = expand5(c1[15:11]);
      e1[1] = expand6(c1[10:5]);
      e1[2] = expand5(c1[4:0]);
      for (int i = 0; i < 3; i++) begin
         if (four) begin
            p2[i] = div3({1'b0, e0[i], 1'b0} + 10'(e1[i]) + 10'd1);
            p3[i] = div3(10'(e0[i]) + {1'b0, e1[i], 1'b0} + 10'd1);
         end else begin
            p2[i] = 8'((9'(e0[i]) + 9'(e1[i])) >> 1);
            p3[i] = 8'd0;
         end
      end
   end

   // Alpha palette: six interpolated steps, or four plus 0 and 255
   always_comb begin
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int i = 0; i < 6; i++)
            apal[2 + i] = div7(11'(6 - i) * 11'(a0) + 11'(1 + i) * 11'(a1) + 11'd3);
      end else begin
         for (int i = 0; i < 4; i++)
            apal[2 + i] = div5(11'(4 - i) * 11'(a0) + 11'(1 + i) * 11'(a1) + 11'd2);
         apal[6] = 8'd0;
         apal[7] = 8'd255;
      end
   end

   always_comb begin
      palette.color[0] = '{r: e0[0], g: e0[1], b: e0[2], a: 8'd255};
      palette.color[1] = '{r: e1[0], g: e1[1], b: e1[2], a: 8'd255};
      palette.color[2] = '{r: p2[0], g: p2[1], b: p2[2], a: 8'd255};
      palette.color[3] = '{r: p3[0], g: p3[1], b: p3[2], a: (four ? 8'd255 : 8'd0)};
      for (int i = 0; i < 8; i++)
         palette.alpha[i] = apal[i];
   end

endmodule

### hdl/dxt_block_texture_decoder.sv
// Top level of the DXT1/DXT3/DXT5 block texture decoder.
// Usage:
//  - req channel: one compressed 4x4 block per request, in raster block order;
//    colour half in tdata[63:0], alpha half in tdata[127:64].
//  - rsp channel: one RGBA pixel per transfer with image coordinates, raster
//    order inside the block; tlast marks the block's last emitted pixel,
//    tuser the last pixel of the image.
//  - csr port: format, width, height; write only while the block is idle.
// Timing: a block is decoded into the block register in the cycle it is
// taken; the pixel sequencer then registers its pixels into the rsp output
// register. The sequencer walks the sixteen pixels one per cycle while rsp
// is not stalled, whatever the cropping (cropped pixels are skipped slots).
// A new block is taken in the cycle its predecessor's last pixel moves out,
// so blocks follow back to back. A fully cropped block yields no pixel but
// still moves the block position.
// Stall: the pixel sequencer only moves while the rsp output register is
// empty or being taken, so a stalled receiver holds everything in place.
// Reset: block position 0,0, DXT1, 512x512, both stages empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dxt_block_texture_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // color_block[63:0], alpha_block[127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // pixel_x[11:0], pixel_y[23:12], red[31:24],
                                     // green[39:32], blue[47:40], alpha[55:48]
   output logic         rsp_tlast,   // last_of_block
   output logic         rsp_tuser,   // image_done
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [12:0]  csr_wdata
);

   localparam int SW = dxt_pkg::SIDE_W;
   localparam int BW = dxt_pkg::BLK_W;
   localparam int CW = dxt_pkg::COORD_W;

   // ---------------- configuration registers ----------------
   logic [1:0]    fmt_ff;
   logic [SW-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= dxt_pkg::FMT_DXT1;
         width_ff  <= dxt_pkg::WIDTH_RESET;
         height_ff <= dxt_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            dxt_pkg::CSR_FORMAT: fmt_ff    <= csr_wdata[1:0];
            dxt_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            dxt_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamped sides and block counts (at least one)
   logic [SW-1:0] side_w, side_h;
   logic [BW:0]   cols, rows;

   assign side_w = (width_ff  > dxt_pkg::MAX_IMAGE_SIDE) ? dxt_pkg::MAX_IMAGE_SIDE : width_ff;
   assign side_h = (height_ff > dxt_pkg::MAX_IMAGE_SIDE) ? dxt_pkg::MAX_IMAGE_SIDE : height_ff;
   assign cols   = (side_w[SW-1:2] == '0) ? (BW+1)'(1) : (BW+1)'(side_w[SW-1:2]);
   assign rows   = (side_h[SW-1:2] == '0) ? (BW+1)'(1) : (BW+1)'(side_h[SW-1:2]);

   // ---------------- block position ----------------
   logic [BW-1:0] col_ff, col_in, row_ff, row_in;
   logic [BW:0]   col_inc, row_inc;
   logic          req_fire;
   logic          last_block;

   assign req_fire   = req_tvalid && req_tready;
   assign col_inc    = (BW+1)'(col_ff) + (BW+1)'(1);
   assign row_inc    = (BW+1)'(row_ff) + (BW+1)'(1);
   assign last_block = (col_inc >= cols) && (row_inc >= rows);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_inc >= cols) begin
            col_in = '0;
            row_in = (row_inc >= rows) ? '0 : row_inc[BW-1:0];
         end else begin
            col_in = col_inc[BW-1:0];
         end
      end
   end

   // Visible columns / rows of the incoming block (0..4)
   logic [CW-1:0] x0, y0;
   logic [SW-1:0] x_room, y_room;
   logic [2:0]    nx, ny;

   assign x0     = {col_ff, 2'b00};
   assign y0     = {row_ff, 2'b00};
   assign x_room = side_w - SW'(x0);
   assign y_room = side_h - SW'(y0);
   assign nx     = (side_w <= SW'(x0)) ? 3'd0 : ((x_room >= SW'(4)) ? 3'd4 : x_room[2:0]);
   assign ny     = (side_h <= SW'(y0)) ? 3'd0 : ((y_room >= SW'(4)) ? 3'd4 : y_room[2:0]);

   // ---------------- palette decode into the block register ----------------
   dxt_pkg::palette_type palette;

   dxt_palette u_palette (
      .color_block  (req_tdata[63:0]),
      .alpha_block  (req_tdata[127:64]),
      .block_format (fmt_ff),
      .palette      (palette)
   );

   dxt_pkg::palette_type pal_ff;
   logic [31:0]   cidx_ff;
   logic [63:0]   araw_ff;
   logic [1:0]    bfmt_ff;
   logic [CW-1:0] bx0_ff, by0_ff;
   logic [2:0]    nx_ff, ny_ff;
   logic          blast_ff;
   logic          blk_valid_ff, blk_valid_in;
   logic [3:0]    pix_ff, pix_in;

   // ---------------- pixel sequencer ----------------
   logic          advance;
   logic [1:0]    px, py, ci;
   logic [5:0]    a5_pos;
   logic          visible, last_pix;
   dxt_pkg::color_type texel;
   logic [7:0]    alpha_sel;

   assign advance    = blk_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !blk_valid_ff || (advance && (pix_ff == 4'd15));

   assign px       = pix_ff[1:0];
   assign py       = pix_ff[3:2];
   assign ci       = cidx_ff[{pix_ff, 1'b0} +: 2];
   assign a5_pos   = 6'd16 + {2'b00, pix_ff} + {1'b0, pix_ff, 1'b0};
   assign texel    = pal_ff.color[ci];
   assign visible  = ({1'b0, px} < nx_ff) && ({1'b0, py} < ny_ff);
   assign last_pix = ({1'b0, px} == nx_ff - 3'd1) && ({1'b0, py} == ny_ff - 3'd1);

   always_comb begin
      case (bfmt_ff)
         dxt_pkg::FMT_DXT3: alpha_sel = {2{araw_ff[{pix_ff, 2'b00} +: 4]}};  // nibble * 17
         dxt_pkg::FMT_DXT5: alpha_sel = pal_ff.alpha[araw_ff[a5_pos +: 3]];
         default:           alpha_sel = texel.a;
      endcase
   end

   always_comb begin
      blk_valid_in = blk_valid_ff;
      pix_in       = pix_ff;
      if (advance) begin
         pix_in = pix_ff + 4'd1;
         if (pix_ff == 4'd15)
            blk_valid_in = 1'b0;
      end
      if (req_fire) begin
         blk_valid_in = 1'b1;
         pix_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         pix_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         pix_ff       <= pix_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pal_ff   <= palette;
         cidx_ff  <= req_tdata[63:32];
         araw_ff  <= req_tdata[127:64];
         bfmt_ff  <= fmt_ff;
         bx0_ff   <= x0;
         by0_ff   <= y0;
         nx_ff    <= nx;
         ny_ff    <= ny;
         blast_ff <= last_block;
      end
   end

   // ---------------- result register ----------------
   logic          out_valid_ff, out_valid_in;
   logic [CW-1:0] ox_ff, oy_ff;
   dxt_pkg::color_type opix_ff;
   logic          olast_ff, odone_ff;

   always_comb begin
      if (advance)
         out_valid_in = visible;
      else if (rsp_tready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance && visible) begin
         ox_ff    <= bx0_ff + CW'(px);
         oy_ff    <= by0_ff + CW'(py);
         opix_ff  <= '{r: texel.r, g: texel.g, b: texel.b, a: alpha_sel};
         olast_ff <= last_pix;
         odone_ff <= last_pix && blast_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {opix_ff.a, opix_ff.b, opix_ff.g, opix_ff.r, oy_ff, ox_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = odone_ff;

   // ---------------- assertions ----------------
   `ASSERT_AT(a_take_restarts, clock, reset,
              req_fire |=> (blk_valid_ff && pix_ff == 4'd0),
              "taken block does not start at pixel zero")
   `ASSERT_NEVER(a_no_overrun, clock, reset,
                 req_tready && blk_valid_ff && pix_ff != 4'd15,
                 "block taken while the held block still has pixels")
   `ASSERT_NEVER(a_done_on_last, clock, reset,
                 rsp_tvalid && rsp_tuser && !rsp_tlast,
                 "image done flagged on a pixel that is not last of block")

endmodule
